>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check that prop holds at every edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// check that cond never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/cgam_pkg.sv
// ----------------------------------------------------------------------------
// CJK glyph atlas mapper package
// Shared types, register codes and atlas geometry constants.
// ----------------------------------------------------------------------------
package cgam_pkg;

    localparam int ATLAS_SPAN = 1024;

    localparam int CODE_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 14;
    localparam int PAGE_W   = 4;
    localparam int POS_W    = 6;
    localparam int S_W      = 11;
    localparam int T_W      = 12;
    localparam int PAGES_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int TEX_W    = 17;

    localparam int ACROSS_KOR = 32;
    localparam int ACROSS_WIDE = 64;
    localparam int CW_KOR  = ATLAS_SPAN / ACROSS_KOR;
    localparam int CW_WIDE = ATLAS_SPAN / ACROSS_WIDE;
    localparam int CH_KOR_HALF  = ATLAS_SPAN / (ACROSS_KOR / 2);
    localparam int CH_WIDE_HALF = ATLAS_SPAN / (ACROSS_WIDE / 2);

    localparam logic [BYTE_W-1:0] KOR_HI_FIRST = 8'hB0;
    localparam logic [BYTE_W-1:0] KOR_HI_LAST  = 8'hC8;
    localparam logic [BYTE_W-1:0] KOR_LO_BASE  = 8'hA0;
    localparam logic [BYTE_W-1:0] KOR_LO_END   = 8'hFF;
    localparam logic [IDX_W-1:0]  KOR_ROW      = 14'd96;

    localparam logic [BYTE_W-1:0] B5_HI_FIRST  = 8'hA1;
    localparam logic [BYTE_W-1:0] B5_HI_GAP_LO = 8'hC6;
    localparam logic [BYTE_W-1:0] B5_HI_GAP_HI = 8'hC9;
    localparam logic [BYTE_W-1:0] B5_HI_LAST   = 8'hF9;
    localparam logic [BYTE_W-1:0] B5_LO_GAP_HI = 8'hA1;
    localparam logic [BYTE_W-1:0] B5_LO_LAST   = 8'hFE;
    localparam logic [BYTE_W-1:0] B5_LO_SQUEEZE = 8'h60;
    localparam logic [BYTE_W-1:0] B5_LO_GAP    = 8'h20;
    localparam logic [IDX_W-1:0]  B5_ROW       = 14'd160;

    localparam logic [BYTE_W-1:0] LO_FIRST     = 8'h40;
    localparam logic [BYTE_W-1:0] LO_GAP_LO    = 8'h7E;

    localparam logic [BYTE_W-1:0] SJ_HI_FIRST  = 8'h81;
    localparam logic [BYTE_W-1:0] SJ_HI_GAP_LO = 8'h9F;
    localparam logic [BYTE_W-1:0] SJ_HI_GAP_HI = 8'hE0;
    localparam logic [BYTE_W-1:0] SJ_HI_LAST   = 8'hEF;
    localparam logic [BYTE_W-1:0] SJ_LO_GAP_HI = 8'h80;
    localparam logic [BYTE_W-1:0] SJ_LO_LAST   = 8'hFC;
    localparam logic [BYTE_W-1:0] SJ_LO_SQUEEZE = 8'h40;
    localparam logic [BYTE_W-1:0] SJ_HI_SQUEEZE = 8'h5F;
    localparam logic [BYTE_W-1:0] SJ_HI_GAP    = 8'h40;
    localparam logic [IDX_W-1:0]  SJ_ROW       = 14'd188;

    typedef enum logic [1:0] {
        LANG_WESTERN = 2'd0,
        LANG_KOREAN  = 2'd1,
        LANG_BIG5    = 2'd2,
        LANG_SJIS    = 2'd3
    } lang_t;

    localparam logic [CFG_IDX_W-1:0] REG_LANGUAGE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES_LOADED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LAST_PAGE = 2'd2;

    typedef struct packed {
        lang_t               language;
        logic [PAGES_W-1:0]  pages_loaded;
        logic                half_last_page;
    } cfg_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_index;
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        logic [S_W-1:0]    tex_s0;
        logic [T_W-1:0]    tex_t0;
        logic [S_W-1:0]    tex_s1;
        logic [T_W-1:0]    tex_t1;
    } place_t;

endpackage

>>> hw/rtl/cgam_collapse.sv
// ----------------------------------------------------------------------------
// Code collapse
// Range-checks a double-byte code for the selected language and folds it
// into a dense glyph index; 0 when the code is not valid.
// ----------------------------------------------------------------------------
module cgam_collapse
(
    input  cgam_pkg::lang_t                  language,
    input  logic [cgam_pkg::CODE_W-1:0]      char_code,
    output logic [cgam_pkg::IDX_W-1:0]       glyph_idx
);

    logic [cgam_pkg::BYTE_W-1:0] hi;
    logic [cgam_pkg::BYTE_W-1:0] lo;
    logic                        kor_ok;
    logic                        b5_ok;
    logic                        sj_ok;
    logic [cgam_pkg::BYTE_W-1:0] kor_h;
    logic [cgam_pkg::BYTE_W-1:0] kor_l;
    logic [cgam_pkg::BYTE_W-1:0] b5_h;
    logic [cgam_pkg::BYTE_W-1:0] b5_l;
    logic [cgam_pkg::BYTE_W-1:0] sj_h;
    logic [cgam_pkg::BYTE_W-1:0] sj_l;
    logic [cgam_pkg::BYTE_W-1:0] lo_off;
    logic [cgam_pkg::BYTE_W-1:0] sj_h_off;
    logic [cgam_pkg::IDX_W-1:0]  kor_idx;
    logic [cgam_pkg::IDX_W-1:0]  b5_idx;
    logic [cgam_pkg::IDX_W-1:0]  sj_idx;

    assign hi = char_code[cgam_pkg::CODE_W-1:cgam_pkg::BYTE_W];
    assign lo = char_code[cgam_pkg::BYTE_W-1:0];

    assign kor_ok = (hi >= cgam_pkg::KOR_HI_FIRST) && (hi <= cgam_pkg::KOR_HI_LAST)
                 && (lo > cgam_pkg::KOR_LO_BASE) && (lo < cgam_pkg::KOR_LO_END);

    assign b5_ok = (((hi >= cgam_pkg::B5_HI_FIRST) && (hi <= cgam_pkg::B5_HI_GAP_LO))
                 || ((hi >= cgam_pkg::B5_HI_GAP_HI) && (hi <= cgam_pkg::B5_HI_LAST)))
                && (((lo >= cgam_pkg::LO_FIRST) && (lo <= cgam_pkg::LO_GAP_LO))
                 || ((lo >= cgam_pkg::B5_LO_GAP_HI) && (lo <= cgam_pkg::B5_LO_LAST)));

    assign sj_ok = (((hi >= cgam_pkg::SJ_HI_FIRST) && (hi <= cgam_pkg::SJ_HI_GAP_LO))
                 || ((hi >= cgam_pkg::SJ_HI_GAP_HI) && (hi <= cgam_pkg::SJ_HI_LAST)))
                && (((lo >= cgam_pkg::LO_FIRST) && (lo <= cgam_pkg::LO_GAP_LO))
                 || ((lo >= cgam_pkg::SJ_LO_GAP_HI) && (lo <= cgam_pkg::SJ_LO_LAST)));

    assign kor_h  = hi - cgam_pkg::KOR_HI_FIRST;
    assign kor_l  = lo - cgam_pkg::KOR_LO_BASE;
    assign lo_off = lo - cgam_pkg::LO_FIRST;
    assign b5_h   = hi - cgam_pkg::B5_HI_FIRST;
    assign sj_h_off = hi - cgam_pkg::SJ_HI_FIRST;

    // squeeze out the trail-byte and lead-byte gaps
    assign b5_l = (lo_off >= cgam_pkg::B5_LO_SQUEEZE) ? (lo_off - cgam_pkg::B5_LO_GAP)
                                                      : lo_off;
    assign sj_l = (lo_off >= cgam_pkg::SJ_LO_SQUEEZE) ? (lo_off - 8'd1) : lo_off;
    assign sj_h = (sj_h_off >= cgam_pkg::SJ_HI_SQUEEZE) ? (sj_h_off - cgam_pkg::SJ_HI_GAP)
                                                        : sj_h_off;

    assign kor_idx = cgam_pkg::IDX_W'(kor_h[4:0]) * cgam_pkg::KOR_ROW
                   + cgam_pkg::IDX_W'(kor_l);
    assign b5_idx  = cgam_pkg::IDX_W'(b5_h[6:0]) * cgam_pkg::B5_ROW
                   + cgam_pkg::IDX_W'(b5_l);
    assign sj_idx  = cgam_pkg::IDX_W'(sj_h[6:0]) * cgam_pkg::SJ_ROW
                   + cgam_pkg::IDX_W'(sj_l);

    always_comb
    begin
        case (language)
            cgam_pkg::LANG_KOREAN: glyph_idx = kor_ok ? kor_idx : '0;
            cgam_pkg::LANG_BIG5:   glyph_idx = b5_ok ? b5_idx : '0;
            cgam_pkg::LANG_SJIS:   glyph_idx = sj_ok ? sj_idx : '0;
            default:               glyph_idx = '0;
        endcase
    end

endmodule

>>> hw/rtl/cgam_place.sv
// ----------------------------------------------------------------------------
// Atlas placement
// Splits a glyph index into page, column and row and forms the four
// texture corners with the per-language inset.
// ----------------------------------------------------------------------------
module cgam_place
(
    input  cgam_pkg::cfg_t                cfg,
    input  logic [cgam_pkg::IDX_W-1:0]    glyph_idx,
    output cgam_pkg::place_t              place
);

    logic                            korean;
    logic [cgam_pkg::PAGE_W-1:0]     raw_page;
    logic [cgam_pkg::PAGE_W-1:0]     page;
    logic [cgam_pkg::POS_W-1:0]      col;
    logic [cgam_pkg::POS_W-1:0]      row;
    logic                            last_half;
    logic [cgam_pkg::TEX_W-1:0]      cw;
    logic [cgam_pkg::TEX_W-1:0]      ch;
    logic [cgam_pkg::TEX_W-1:0]      s0;
    logic [cgam_pkg::TEX_W-1:0]      s1;
    logic [cgam_pkg::TEX_W-1:0]      t0;
    logic [cgam_pkg::TEX_W-1:0]      t1;

    assign korean = (cfg.language == cgam_pkg::LANG_KOREAN);

    always_comb
    begin
        if (korean)
        begin
            raw_page = glyph_idx[13:10];
            col      = {1'b0, glyph_idx[4:0]};
            row      = {1'b0, glyph_idx[9:5]};
        end
        else
        begin
            raw_page = {2'b00, glyph_idx[13:12]};
            col      = glyph_idx[5:0];
            row      = glyph_idx[11:6];
        end
    end

    // drop to page 0 when the page is not loaded
    assign page = (cgam_pkg::PAGES_W'(raw_page) >= cfg.pages_loaded) ? '0 : raw_page;

    assign last_half = cfg.half_last_page && (cfg.pages_loaded != '0)
                    && (cgam_pkg::PAGES_W'(page) == (cfg.pages_loaded - 5'd1));

    always_comb
    begin
        if (korean)
        begin
            cw = cgam_pkg::TEX_W'(cgam_pkg::CW_KOR);
            ch = last_half ? cgam_pkg::TEX_W'(cgam_pkg::CH_KOR_HALF)
                           : cgam_pkg::TEX_W'(cgam_pkg::CW_KOR);
        end
        else
        begin
            cw = cgam_pkg::TEX_W'(cgam_pkg::CW_WIDE);
            ch = last_half ? cgam_pkg::TEX_W'(cgam_pkg::CH_WIDE_HALF)
                           : cgam_pkg::TEX_W'(cgam_pkg::CW_WIDE);
        end
    end

    always_comb
    begin
        s0 = cw * cgam_pkg::TEX_W'(col);
        s1 = s0 + cw;
        t0 = ch * cgam_pkg::TEX_W'(row);
        t1 = t0 + ch;
        case (cfg.language)
            cgam_pkg::LANG_BIG5:
            begin
                s0 = s0 + 17'd1;
                t0 = t0 + 17'd1;
            end
            cgam_pkg::LANG_SJIS:
            begin
                s1 = s1 - 17'd1;
                t1 = t1 - 17'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign place.page_index = page;
    assign place.column     = col;
    assign place.row        = row;
    assign place.tex_s0     = s0[cgam_pkg::S_W-1:0];
    assign place.tex_t0     = t0[cgam_pkg::T_W-1:0];
    assign place.tex_s1     = s1[cgam_pkg::S_W-1:0];
    assign place.tex_t1     = t1[cgam_pkg::T_W-1:0];

endmodule

>>> hw/rtl/cjk_glyph_atlas_mapper.sv
// ----------------------------------------------------------------------------
// CJK glyph atlas mapper
// Maps a double-byte character code to a glyph page, cell and texture
// corners in the atlas, or to the western glyph table.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   char_code
//   out      output     out_valid / out_ready use_asian .. western_index
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Two register stages: the collapsed index is registered, then the placed
// result. Throughput is one item per cycle while the output is not stalled.
// Stalls propagate back stage by stage; each stage takes a new item as soon
// as the stage ahead of it frees. cfg_ready is always high.
// Reset empties both stages and loads language 0, four pages, half last page.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cjk_glyph_atlas_mapper
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cgam_pkg::CODE_W-1:0]         char_code,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                use_asian,
    output logic [cgam_pkg::IDX_W-1:0]          glyph_index,
    output logic [cgam_pkg::PAGE_W-1:0]         page_index,
    output logic [cgam_pkg::POS_W-1:0]          column,
    output logic [cgam_pkg::POS_W-1:0]          row,
    output logic [cgam_pkg::S_W-1:0]            tex_s0,
    output logic [cgam_pkg::T_W-1:0]            tex_t0,
    output logic [cgam_pkg::S_W-1:0]            tex_s1,
    output logic [cgam_pkg::T_W-1:0]            tex_t1,
    output logic [cgam_pkg::BYTE_W-1:0]         western_index,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cgam_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cgam_pkg::CFG_DATA_W-1:0]     cfg_data
);

    cgam_pkg::cfg_t                  cfg_reg;
    logic                            s1_valid_reg;
    logic [cgam_pkg::IDX_W-1:0]      s1_idx_reg;
    logic [cgam_pkg::BYTE_W-1:0]     s1_lo_reg;
    logic                            out_valid_reg;
    logic                            use_asian_reg;
    logic [cgam_pkg::IDX_W-1:0]      glyph_reg;
    cgam_pkg::place_t                place_reg;
    logic [cgam_pkg::BYTE_W-1:0]     western_reg;

    logic [cgam_pkg::IDX_W-1:0]      idx_next;
    cgam_pkg::place_t                place_next;
    logic                            s2_ready;
    logic                            hit;

    assign cfg_ready = 1'b1;
    assign s2_ready  = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s2_ready;
    assign hit       = (s1_idx_reg != '0);

    cgam_collapse u_collapse
    (
        .language  (cfg_reg.language),
        .char_code (char_code),
        .glyph_idx (idx_next)
    );

    cgam_place u_place
    (
        .cfg       (cfg_reg),
        .glyph_idx (s1_idx_reg),
        .place     (place_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.language       <= cgam_pkg::LANG_WESTERN;
            cfg_reg.pages_loaded   <= 5'd4;
            cfg_reg.half_last_page <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cgam_pkg::REG_LANGUAGE:
                    cfg_reg.language <= cgam_pkg::lang_t'(cfg_data[1:0]);
                cgam_pkg::REG_PAGES_LOADED:
                    cfg_reg.pages_loaded <= cfg_data;
                cgam_pkg::REG_HALF_LAST_PAGE:
                    cfg_reg.half_last_page <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_idx_reg <= idx_next;
            s1_lo_reg  <= char_code[cgam_pkg::BYTE_W-1:0];
        end
        if (s1_valid_reg && s2_ready)
        begin
            use_asian_reg <= hit;
            glyph_reg     <= s1_idx_reg;
            place_reg     <= hit ? place_next : '0;
            western_reg   <= s1_lo_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign use_asian     = use_asian_reg;
    assign glyph_index   = glyph_reg;
    assign page_index    = place_reg.page_index;
    assign column        = place_reg.column;
    assign row           = place_reg.row;
    assign tex_s0        = place_reg.tex_s0;
    assign tex_t0        = place_reg.tex_t0;
    assign tex_s1        = place_reg.tex_s1;
    assign tex_t1        = place_reg.tex_t1;
    assign western_index = western_reg;

    `ASSERT_PROP(a_asian_nonzero, clk, rst_n,
        out_valid_reg && use_asian_reg |-> glyph_reg != '0)
    `ASSERT_PROP(a_miss_zero, clk, rst_n,
        out_valid_reg && !use_asian_reg |-> glyph_reg == '0 && place_reg == '0)
    `ASSERT_PROP(a_page_loaded, clk, rst_n,
        out_valid_reg && use_asian_reg |->
            cgam_pkg::PAGES_W'(place_reg.page_index) < cfg_reg.pages_loaded
            || place_reg.page_index == '0)
    `ASSERT_PROP(a_stage_hold, clk, rst_n,
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_idx_reg))
    `ASSERT_NEVER(a_western_miss, clk, rst_n,
        out_valid_reg && use_asian_reg && cfg_reg.language == cgam_pkg::LANG_WESTERN)

endmodule

>>> verif/cjk_glyph_atlas_mapper_tb.sv
// ----------------------------------------------------------------------------
// CJK glyph atlas mapper testbench
// Runs a short list of hand-picked character codes first. Where the answer is
// obvious it is typed into the list. Random codes follow, most of them valid
// for the selected language, in blocks, and each block loads a new register
// setting. Each result is checked against its typed answer or an in-bench mapper
// model; in later blocks the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module cjk_glyph_atlas_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cgam_pkg::*;

    typedef struct packed {
        logic               use_asian;
        logic [IDX_W-1:0]   glyph_index;
        place_t             place;
        logic [BYTE_W-1:0]  western_index;
    } glyph_result_t;

    typedef struct {
        lang_t               lang;
        logic [PAGES_W-1:0]  pages;
        logic                half;
        logic [CODE_W-1:0]   code;
        bit                  typed;
        glyph_result_t       want;
    } code_probe_t;

    localparam int PROBE_ROWS   = 24;
    localparam int BLOCKS       = 16;
    localparam int BLOCK_ITEMS  = 47;
    localparam int CYCLE_LIMIT  = 300000;

    localparam int SEND_IDLE_PCT [4] = '{0, 79, 0, 22};
    localparam int STALL_PCT     [4] = '{0, 0, 79, 22};
    localparam logic [PAGES_W-1:0] PAGE_CHOICES [8] =
        '{5'd1, 5'd16, 5'd2, 5'd3, 5'd4, 5'd0, 5'd31, 5'd5};

    code_probe_t probe_table [PROBE_ROWS] = '{
        '{LANG_WESTERN, 5'd4,  1'b1, 16'h0000, 1'b1, '{1'b0, 14'd0, '0, 8'h00}},
        '{LANG_WESTERN, 5'd4,  1'b1, 16'hFFFF, 1'b1, '{1'b0, 14'd0, '0, 8'hFF}},
        '{LANG_WESTERN, 5'd4,  1'b1, 16'hB0A1, 1'b1, '{1'b0, 14'd0, '0, 8'hA1}},
        '{LANG_KOREAN,  5'd4,  1'b1, 16'hB0A0, 1'b1, '{1'b0, 14'd0, '0, 8'hA0}},
        '{LANG_KOREAN,  5'd4,  1'b1, 16'hB0A1, 1'b1,
          '{1'b1, 14'd1, '{4'd0, 6'd1, 6'd0, 11'd32, 12'd0, 11'd64, 12'd32}, 8'hA1}},
        '{LANG_KOREAN,  5'd4,  1'b1, 16'hC8FE, 1'b0, '0},
        '{LANG_KOREAN,  5'd4,  1'b1, 16'hC8FF, 1'b1, '{1'b0, 14'd0, '0, 8'hFF}},
        '{LANG_KOREAN,  5'd4,  1'b1, 16'hAFFE, 1'b1, '{1'b0, 14'd0, '0, 8'hFE}},
        '{LANG_KOREAN,  5'd3,  1'b1, 16'hC8FE, 1'b0, '0},
        '{LANG_KOREAN,  5'd1,  1'b1, 16'hBBA1, 1'b0, '0},
        '{LANG_BIG5,    5'd3,  1'b1, 16'hA140, 1'b1, '{1'b0, 14'd0, '0, 8'h40}},
        '{LANG_BIG5,    5'd3,  1'b1, 16'hA17E, 1'b0, '0},
        '{LANG_BIG5,    5'd3,  1'b1, 16'hA1A1, 1'b0, '0},
        '{LANG_BIG5,    5'd3,  1'b1, 16'hA17F, 1'b1, '{1'b0, 14'd0, '0, 8'h7F}},
        '{LANG_BIG5,    5'd3,  1'b1, 16'hC7A1, 1'b1, '{1'b0, 14'd0, '0, 8'hA1}},
        '{LANG_BIG5,    5'd3,  1'b1, 16'hEDDF, 1'b0, '0},
        '{LANG_BIG5,    5'd3,  1'b1, 16'hF9FE, 1'b0, '0},
        '{LANG_BIG5,    5'd0,  1'b1, 16'hF9FE, 1'b0, '0},
        '{LANG_SJIS,    5'd31, 1'b0, 16'h8140, 1'b1, '{1'b0, 14'd0, '0, 8'h40}},
        '{LANG_SJIS,    5'd31, 1'b0, 16'h817F, 1'b1, '{1'b0, 14'd0, '0, 8'h7F}},
        '{LANG_SJIS,    5'd31, 1'b0, 16'h8180, 1'b0, '0},
        '{LANG_SJIS,    5'd31, 1'b0, 16'hE040, 1'b0, '0},
        '{LANG_SJIS,    5'd31, 1'b0, 16'hEFFC, 1'b0, '0},
        '{LANG_SJIS,    5'd31, 1'b0, 16'hA040, 1'b1, '{1'b0, 14'd0, '0, 8'h40}}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [CODE_W-1:0]      char_code = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   use_asian;
    logic [IDX_W-1:0]       glyph_index;
    logic [PAGE_W-1:0]      page_index;
    logic [POS_W-1:0]       column;
    logic [POS_W-1:0]       row;
    logic [S_W-1:0]         tex_s0;
    logic [T_W-1:0]         tex_t0;
    logic [S_W-1:0]         tex_s1;
    logic [T_W-1:0]         tex_t1;
    logic [BYTE_W-1:0]      western_index;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    lang_t                  shadow_lang = LANG_WESTERN;
    logic [PAGES_W-1:0]     shadow_pages = 5'd4;
    logic                   shadow_half = 1'b1;

    glyph_result_t          expected_glyphs [$];
    int                     mismatches = 0;
    int                     cycle_count = 0;
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;

    cjk_glyph_atlas_mapper dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .use_asian     (use_asian),
        .glyph_index   (glyph_index),
        .page_index    (page_index),
        .column        (column),
        .row           (row),
        .tex_s0        (tex_s0),
        .tex_t0        (tex_t0),
        .tex_s1        (tex_s1),
        .tex_t1        (tex_t1),
        .western_index (western_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5ns clk = ~clk;

    function automatic glyph_result_t predict_glyph(input logic [CODE_W-1:0] code);
        int hi;
        int lo;
        int idx;
        int l;
        int h;
        int across;
        int page;
        int rem;
        int col;
        int rw;
        int down;
        int cw;
        int chh;
        int s0;
        int t0;
        int s1;
        int t1;
        int npages;
        glyph_result_t r;
        hi = code[15:8];
        lo = code[7:0];
        idx = 0;
        npages = shadow_pages;
        case (shadow_lang)
            LANG_KOREAN:
            begin
                if (hi >= 8'hB0 && hi <= 8'hC8 && lo > 8'hA0 && lo < 8'hFF)
                    idx = (hi - 8'hB0) * 96 + (lo - 8'hA0);
            end
            LANG_BIG5:
            begin
                if (((hi >= 8'hA1 && hi <= 8'hC6) || (hi >= 8'hC9 && hi <= 8'hF9)) &&
                    ((lo >= 8'h40 && lo <= 8'h7E) || (lo >= 8'hA1 && lo <= 8'hFE)))
                begin
                    l = lo - 8'h40;
                    if (l >= 8'h60)
                        l -= 8'h20;
                    idx = (hi - 8'hA1) * 160 + l;
                end
            end
            LANG_SJIS:
            begin
                if (((hi >= 8'h81 && hi <= 8'h9F) || (hi >= 8'hE0 && hi <= 8'hEF)) &&
                    ((lo >= 8'h40 && lo <= 8'h7E) || (lo >= 8'h80 && lo <= 8'hFC)))
                begin
                    l = lo - 8'h40;
                    if (l >= 8'h40)
                        l -= 1;
                    h = hi - 8'h81;
                    if (h >= 8'h5F)
                        h -= 8'h40;
                    idx = h * 188 + l;
                end
            end
            default:
                idx = 0;
        endcase
        r = '0;
        r.western_index = code[7:0];
        if (idx != 0)
        begin
            across = (shadow_lang == LANG_KOREAN) ? 32 : 64;
            page = idx / (across * across);
            rem = idx % (across * across);
            if (page >= npages)
                page = 0;
            col = rem % across;
            rw = rem / across;
            down = (shadow_half && npages != 0 && page == npages - 1) ? across / 2 : across;
            cw = ATLAS_SPAN / across;
            chh = ATLAS_SPAN / down;
            s0 = cw * col;
            s1 = cw * (col + 1);
            t0 = chh * rw;
            t1 = chh * (rw + 1);
            if (shadow_lang == LANG_BIG5)
            begin
                s0 += 1;
                t0 += 1;
            end
            else if (shadow_lang == LANG_SJIS)
            begin
                s1 -= 1;
                t1 -= 1;
            end
            r.use_asian = 1'b1;
            r.glyph_index = idx[IDX_W-1:0];
            r.place.page_index = page[PAGE_W-1:0];
            r.place.column = col[POS_W-1:0];
            r.place.row = rw[POS_W-1:0];
            r.place.tex_s0 = s0[S_W-1:0];
            r.place.tex_t0 = t0[T_W-1:0];
            r.place.tex_s1 = s1[S_W-1:0];
            r.place.tex_t1 = t1[T_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] pick_code(input lang_t lang);
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        if (lang == LANG_WESTERN || $urandom_range(99) < 20)
            return CODE_W'($urandom);
        case (lang)
            LANG_KOREAN:
            begin
                hi = BYTE_W'($urandom_range(8'hC8, 8'hB0));
                lo = BYTE_W'($urandom_range(8'hFE, 8'hA1));
            end
            LANG_BIG5:
            begin
                hi = BYTE_W'($urandom_range(1) ? $urandom_range(8'hC6, 8'hA1)
                                               : $urandom_range(8'hF9, 8'hC9));
                lo = BYTE_W'($urandom_range(1) ? $urandom_range(8'h7E, 8'h40)
                                               : $urandom_range(8'hFE, 8'hA1));
            end
            default:
            begin
                hi = BYTE_W'($urandom_range(1) ? $urandom_range(8'h9F, 8'h81)
                                               : $urandom_range(8'hEF, 8'hE0));
                lo = BYTE_W'($urandom_range(1) ? $urandom_range(8'h7E, 8'h40)
                                               : $urandom_range(8'hFC, 8'h80));
            end
        endcase
        return {hi, lo};
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        end
    endtask

    task automatic compare_glyph(input glyph_result_t want);
        begin
            check_field("use_asian", want.use_asian, use_asian);
            check_field("glyph_index", want.glyph_index, glyph_index);
            check_field("page_index", want.place.page_index, page_index);
            check_field("column", want.place.column, column);
            check_field("row", want.place.row, row);
            check_field("tex_s0", want.place.tex_s0, tex_s0);
            check_field("tex_t0", want.place.tex_t0, tex_t0);
            check_field("tex_s1", want.place.tex_s1, tex_s1);
            check_field("tex_t1", want.place.tex_t1, tex_t1);
            check_field("western_index", want.western_index, western_index);
        end
    endtask

    task automatic send_code(input logic [CODE_W-1:0] code, input bit typed,
                             input glyph_result_t want);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            char_code <= code;
            do
                @(posedge clk);
            while (!in_ready);
            if (typed)
                expected_glyphs.push_back(want);
            else
                expected_glyphs.push_back(predict_glyph(code));
            @(negedge clk);
        end
    endtask

    task automatic drain_mapper();
        begin
            in_valid <= 1'b0;
            while (expected_glyphs.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx)
                REG_LANGUAGE:       shadow_lang = lang_t'(data[1:0]);
                REG_PAGES_LOADED:   shadow_pages = data;
                REG_HALF_LAST_PAGE: shadow_half = data[0];
                default:            ;
            endcase
            @(negedge clk);
        end
    endtask

    task automatic load_setup(input lang_t lang, input logic [PAGES_W-1:0] pages,
                              input logic half);
        begin
            put_reg(REG_LANGUAGE, {3'b000, lang});
            put_reg(REG_PAGES_LOADED, pages);
            put_reg(REG_HALF_LAST_PAGE, {4'b0000, half});
            cfg_valid <= 1'b0;
        end
    endtask

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_glyphs.size() == 0)
            begin
                $error("result with no pending item: glyph_index %0d, western_index %0d",
                       glyph_index, western_index);
                mismatches++;
            end
            else
                compare_glyph(expected_glyphs.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int pick;
        logic [PAGES_W-1:0] pages;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PROBE_ROWS; i++)
        begin
            if (probe_table[i].lang != shadow_lang || probe_table[i].pages != shadow_pages ||
                probe_table[i].half != shadow_half)
            begin
                drain_mapper();
                load_setup(probe_table[i].lang, probe_table[i].pages, probe_table[i].half);
            end
            send_code(probe_table[i].code, probe_table[i].typed, probe_table[i].want);
        end

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            drain_mapper();
            send_idle_pct = SEND_IDLE_PCT[blk / 4];
            stall_pct = STALL_PCT[blk / 4];
            pick = (blk + blk / 4) % 8;
            pages = (pick == 7) ? 5'($urandom_range(16, 1)) : PAGE_CHOICES[pick];
            load_setup(lang_t'(blk % 4), pages, 1'($urandom_range(1)));
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_code(pick_code(shadow_lang), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
